### rtl/dhhm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the dual homography height map remap block.
// Depends on nothing; every other file imports it.
package dhhm_pkg;

   localparam int MAP_WIDTH_DEF    = 512;
   localparam int MAP_HEIGHT_DEF   = 256;
   localparam int TARGET_COUNT_DEF = 16;

   localparam int COEF_COUNT   = 18;
   localparam int ROW_COUNT    = 6;
   localparam int SUM_W        = 50;
   localparam int MAG_W        = 50;
   localparam int PROD_W       = 49;
   localparam int ADDR_W       = 25;
   localparam int QUEUE_DEPTH  = 2;
   localparam logic [7:0] THRESH_RESET = 8'd150;

   typedef enum logic [1:0] {
      OP_POINT = 2'd0,
      OP_COEF  = 2'd1,
      OP_MAP   = 2'd2,
      OP_SPARE = 2'd3
   } op_type;

   typedef struct packed {
      op_type             kind;
      logic [3:0]         id;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic [4:0]         coef_index;
      logic signed [31:0] coef_value;
      logic [16:0]        map_addr;
      logic [7:0]         map_value;
   } job_type;

endpackage

### rtl/dhhm_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the front and the back part.
// Depends on dhhm_pkg for the job type and the depth.
module dhhm_fifo import dhhm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty
);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/dhhm_front.sv
`timescale 1ns / 1ps
// Front part: accepts items, drops ignored ones, updates the position table.
// Depends on dhhm_pkg; feeds dhhm_fifo.
module dhhm_front import dhhm_pkg::*; #(
   parameter int MAP_WIDTH    = MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT   = MAP_HEIGHT_DEF,
   parameter int TARGET_COUNT = TARGET_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_target_id,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [4:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic [16:0]        req_map_addr,
   input  logic [7:0]         req_map_value,
   output logic               q_push,
   output job_type            q_data,
   input  logic               q_full
);
   localparam int MAP_SIZE = MAP_WIDTH * MAP_HEIGHT;
   localparam int TIDX_W   = $clog2(TARGET_COUNT);

   typedef enum logic [1:0] {
      F_ACCEPT = 2'b01,
      F_WORK   = 2'b10
   } fstate_type;

   fstate_type        state_ff;
   job_type           job_ff;
   logic              keep_ff;
   logic [31:0]       pos_mem [TARGET_COUNT];
   logic [TARGET_COUNT-1:0] pos_vld_ff;
   logic [31:0]       pos_rd_ff;
   logic              pos_hit_ff;
   logic              accept, keep_in, is_point;
   logic [8:0]        rd_wide, wr_wide;
   logic [TIDX_W-1:0] rd_idx, wr_idx;
   logic [15:0]       old_x, old_y, new_x, new_y;
   logic [16:0]       sum_x, sum_y;

   assign req_full = (state_ff != F_ACCEPT);
   assign accept   = req_push && !req_full;
   assign rd_wide  = {5'd0, req_target_id};
   assign wr_wide  = {5'd0, job_ff.id};
   assign rd_idx   = rd_wide[TIDX_W-1:0];
   assign wr_idx   = wr_wide[TIDX_W-1:0];

   always_comb begin
      keep_in = 1'b0;
      if (req_op == OP_POINT) begin
         keep_in = ({5'd0, req_target_id} < 9'(TARGET_COUNT));
      end else if (req_op == OP_COEF) begin
         keep_in = (req_coef_index < 5'(COEF_COUNT));
      end else if (req_op == OP_MAP) begin
         keep_in = ({8'd0, req_map_addr} < ADDR_W'(MAP_SIZE));
      end
   end

   assign is_point = (job_ff.kind == OP_POINT);
   assign old_x    = pos_hit_ff ? pos_rd_ff[15:0]  : 16'd0;
   assign old_y    = pos_hit_ff ? pos_rd_ff[31:16] : 16'd0;
   assign sum_x    = {1'b0, old_x} + {1'b0, job_ff.pos_x};
   assign sum_y    = {1'b0, old_y} + {1'b0, job_ff.pos_y};
   assign new_x    = (old_x == 16'd0 && old_y == 16'd0) ? job_ff.pos_x : sum_x[16:1];
   assign new_y    = (old_x == 16'd0 && old_y == 16'd0) ? job_ff.pos_y : sum_y[16:1];

   always_comb begin
      q_data       = job_ff;
      q_data.pos_x = new_x;
      q_data.pos_y = new_y;
   end

   assign q_push = (state_ff == F_WORK) && keep_ff && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= F_ACCEPT;
         keep_ff    <= 1'b0;
         pos_vld_ff <= '0;
      end else begin
         unique case (state_ff)
            F_ACCEPT: begin
               if (accept) begin
                  state_ff <= F_WORK;
                  keep_ff  <= keep_in;
               end
            end
            F_WORK: begin
               if (!keep_ff) begin
                  state_ff <= F_ACCEPT;
               end else if (!q_full) begin
                  state_ff <= F_ACCEPT;
                  if (is_point) begin
                     pos_vld_ff[wr_idx] <= 1'b1;
                  end
               end
            end
            default: state_ff <= F_ACCEPT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff.kind       <= op_type'(req_op);
         job_ff.id         <= req_target_id;
         job_ff.pos_x      <= req_pos_x;
         job_ff.pos_y      <= req_pos_y;
         job_ff.coef_index <= req_coef_index;
         job_ff.coef_value <= req_coef_value;
         job_ff.map_addr   <= req_map_addr;
         job_ff.map_value  <= req_map_value;
         pos_rd_ff         <= pos_mem[rd_idx];
         pos_hit_ff        <= pos_vld_ff[rd_idx];
      end
      if (q_push && is_point) begin
         pos_mem[wr_idx] <= {new_y, new_x};
      end
   end

endmodule

### rtl/dhhm_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on dhhm_pkg for the operand width.
module dhhm_div import dhhm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] num,
   input  logic [MAG_W-1:0] den,
   output logic [MAG_W-1:0] quo,
   output logic             done
);
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic [MAG_W-1:0] quo_ff, rem_ff, den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             run_ff, done_ff;
   logic [MAG_W:0]   trial;

   assign trial = {rem_ff, quo_ff[MAG_W-1]} - {1'b0, den_ff};
   assign quo   = quo_ff;
   assign done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(MAG_W);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (run_ff) begin
         if (!trial[MAG_W]) begin
            rem_ff <= trial[MAG_W-1:0];
         end else begin
            rem_ff <= {rem_ff[MAG_W-2:0], quo_ff[MAG_W-1]};
         end
         quo_ff <= {quo_ff[MAG_W-2:0], ~trial[MAG_W]};
      end
   end

endmodule

### rtl/dhhm_back.sv
`timescale 1ns / 1ps
// Back part: coefficient and height map stores, projection and selection.
// Depends on dhhm_pkg and dhhm_div; takes jobs from dhhm_fifo.
module dhhm_back import dhhm_pkg::*; #(
   parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_data,
   output logic       q_pop,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_height_threshold,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [3:0] rsp_out_id,
   output logic [8:0] rsp_map_x,
   output logic [7:0] rsp_map_y,
   output logic       rsp_on_high,
   output logic       rsp_valid_res,
   output logic       rsp_no_data
);
   localparam int MAP_SIZE = MAP_WIDTH * MAP_HEIGHT;
   localparam int MAP_AW   = $clog2(MAP_SIZE);

   typedef enum logic [6:0] {
      B_IDLE  = 7'b0000001,
      B_MUL   = 7'b0000010,
      B_DRAIN = 7'b0000100,
      B_DIVS  = 7'b0001000,
      B_DIVW  = 7'b0010000,
      B_LOOK  = 7'b0100000,
      B_HOLD  = 7'b1000000
   } bstate_type;

   bstate_type               state_ff;
   logic [7:0]               thresh_ff;
   logic signed [31:0]       coef_ff [COEF_COUNT];
   logic [7:0]               hmap_mem [MAP_SIZE];
   logic [7:0]               hmap_rd_ff;
   logic [3:0]               id_ff;
   logic [15:0]              x_ff, y_ff;
   logic [4:0]               cnt_ff;
   logic [2:0]               row_ff, prow_ff;
   logic [1:0]               col_ff;
   logic                     pv_ff;
   logic signed [PROD_W-1:0] product_ff, product_in;
   logic signed [16:0]       opnd;
   logic signed [SUM_W-1:0]  acc_ff [ROW_COUNT];
   logic [MAG_W-1:0]         mag [ROW_COUNT];
   logic [MAG_W-1:0]         qhx, qhy, qlx, qly;
   logic [3:0]               div_done;
   logic                     div_start, all_done;
   logic                     valid_in, valid_ff;
   logic [11:0]              hx_ff, hy_ff;
   logic [8:0]               lx_ff;
   logic [7:0]               ly_ff;
   logic [ADDR_W-1:0]        rd_addr_w, wr_addr_w;
   logic                     rsp_full_ff, slot_free, high;

   function automatic logic qpos(input logic [MAG_W-1:0] q, input logic sn, input logic sd);
      return (q != '0) && (sn == sd);
   endfunction

   assign csr_ready = 1'b1;
   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign div_start = (state_ff == B_DIVS);
   assign all_done  = &div_done;
   assign slot_free = !rsp_full_ff || rsp_pop;
   assign rsp_empty = !rsp_full_ff;

   always_comb begin
      unique case (col_ff)
         2'd0:    opnd = signed'({1'b0, x_ff});
         2'd1:    opnd = signed'({1'b0, y_ff});
         2'd2:    opnd = 17'sd16;
         default: opnd = 17'sd0;
      endcase
   end
   assign product_in = coef_ff[cnt_ff] * opnd;

   always_comb begin
      for (int i = 0; i < ROW_COUNT; i++) begin
         mag[i] = acc_ff[i][SUM_W-1] ? MAG_W'(-acc_ff[i]) : MAG_W'(acc_ff[i]);
      end
   end

   dhhm_div u_div_hx (.clock, .reset, .start(div_start), .num(mag[0]), .den(mag[2]),
                      .quo(qhx), .done(div_done[0]));
   dhhm_div u_div_hy (.clock, .reset, .start(div_start), .num(mag[1]), .den(mag[2]),
                      .quo(qhy), .done(div_done[1]));
   dhhm_div u_div_lx (.clock, .reset, .start(div_start), .num(mag[3]), .den(mag[5]),
                      .quo(qlx), .done(div_done[2]));
   dhhm_div u_div_ly (.clock, .reset, .start(div_start), .num(mag[4]), .den(mag[5]),
                      .quo(qly), .done(div_done[3]));

   assign valid_in = (acc_ff[2] != '0) && (acc_ff[5] != '0)
                  && qpos(qhx, acc_ff[0][SUM_W-1], acc_ff[2][SUM_W-1])
                  && qpos(qhy, acc_ff[1][SUM_W-1], acc_ff[2][SUM_W-1])
                  && qpos(qlx, acc_ff[3][SUM_W-1], acc_ff[5][SUM_W-1])
                  && qpos(qly, acc_ff[4][SUM_W-1], acc_ff[5][SUM_W-1])
                  && (qhx < MAG_W'(MAP_WIDTH)) && (qhy < MAG_W'(MAP_HEIGHT));

   assign rd_addr_w = ADDR_W'(ADDR_W'(hy_ff) * ADDR_W'(MAP_WIDTH) + ADDR_W'(hx_ff));
   assign wr_addr_w = ADDR_W'(q_data.map_addr);
   assign high      = valid_ff && (hmap_rd_ff > thresh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= B_IDLE;
         thresh_ff   <= THRESH_RESET;
         pv_ff       <= 1'b0;
         rsp_full_ff <= 1'b0;
         for (int i = 0; i < COEF_COUNT; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            thresh_ff <= csr_height_threshold;
         end
         pv_ff <= (state_ff == B_MUL);
         if (state_ff == B_HOLD && slot_free) begin
            rsp_full_ff <= 1'b1;
         end else if (rsp_pop && rsp_full_ff) begin
            rsp_full_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  if (q_data.kind == OP_COEF) begin
                     coef_ff[q_data.coef_index] <= q_data.coef_value;
                  end else if (q_data.kind == OP_POINT) begin
                     state_ff <= B_MUL;
                  end
               end
            end
            B_MUL: begin
               if (cnt_ff == 5'(COEF_COUNT - 1)) begin
                  state_ff <= B_DRAIN;
               end
            end
            B_DRAIN: state_ff <= B_DIVS;
            B_DIVS:  state_ff <= B_DIVW;
            B_DIVW: begin
               if (all_done) begin
                  state_ff <= B_LOOK;
               end
            end
            B_LOOK: state_ff <= B_HOLD;
            B_HOLD: begin
               if (slot_free) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.kind == OP_POINT) begin
         id_ff  <= q_data.id;
         x_ff   <= q_data.pos_x;
         y_ff   <= q_data.pos_y;
         cnt_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         for (int i = 0; i < ROW_COUNT; i++) begin
            acc_ff[i] <= '0;
         end
      end else begin
         if (state_ff == B_MUL) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (col_ff == 2'd2) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
         if (pv_ff) begin
            acc_ff[prow_ff] <= acc_ff[prow_ff] + SUM_W'(product_ff);
         end
      end
      product_ff <= product_in;
      prow_ff    <= row_ff;
      if (state_ff == B_DIVW && all_done) begin
         valid_ff <= valid_in;
         hx_ff    <= qhx[11:0];
         hy_ff    <= qhy[11:0];
         lx_ff    <= qlx[8:0];
         ly_ff    <= qly[7:0];
      end
      if (state_ff == B_HOLD && slot_free) begin
         rsp_out_id    <= id_ff;
         rsp_valid_res <= valid_ff;
         rsp_on_high   <= high;
         rsp_no_data   <= (x_ff == 16'd0) && (y_ff == 16'd0);
         rsp_map_x     <= !valid_ff ? 9'd0 : (high ? hx_ff[8:0] : lx_ff);
         rsp_map_y     <= !valid_ff ? 8'd0 : (high ? hy_ff[7:0] : ly_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.kind == OP_MAP) begin
         hmap_mem[wr_addr_w[MAP_AW-1:0]] <= q_data.map_value;
      end
      if (state_ff == B_LOOK) begin
         hmap_rd_ff <= hmap_mem[rd_addr_w[MAP_AW-1:0]];
      end
   end

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_HOLD && slot_free) |-> (!rsp_full_ff || rsp_pop))
      else $error("result slot overwritten");
   a_div_run: assert property (@(posedge clock) disable iff (reset)
      div_start |=> !all_done)
      else $error("divider finished at once");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_full_ff && !rsp_valid_res) |-> (!rsp_on_high && rsp_map_x == 9'd0
                                           && rsp_map_y == 8'd0))
      else $error("invalid result carries a point");

endmodule

### rtl/dual_homography_height_map_remap.sv
`timescale 1ns / 1ps
// Top level of the dual homography height map remap block.
// Depends on dhhm_pkg, dhhm_front, dhhm_fifo, dhhm_back.
//
//   channel  direction  handshake            transfer when
//   req_     in         req_push / req_full  req_push && !req_full
//   rsp_     out        rsp_empty / rsp_pop  rsp_pop && !rsp_empty
//   csr_     in         csr_valid/csr_ready  csr_valid && csr_ready
//
// A point item passes through the back part from queue pop to loaded result: the pop, the
// products on the shared multiplier, a drain, a divider start, the wait while the bit-serial
// dividers run, a map read and a result load.
// Load items pass the accept and work states in the front and are stored in the back on pop.
// Reset is synchronous; the height map is not cleared and holds garbage until written.
// A full result slot stalls the back part; the front keeps accepting until the queue fills.
module dual_homography_height_map_remap import dhhm_pkg::*; #(
   parameter int MAP_WIDTH    = MAP_WIDTH_DEF,
   parameter int MAP_HEIGHT   = MAP_HEIGHT_DEF,
   parameter int TARGET_COUNT = TARGET_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_target_id,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [4:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic [16:0]        req_map_addr,
   input  logic [7:0]         req_map_value,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [3:0]         rsp_out_id,
   output logic [8:0]         rsp_map_x,
   output logic [7:0]         rsp_map_y,
   output logic               rsp_on_high,
   output logic               rsp_valid_res,
   output logic               rsp_no_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_height_threshold
);
   job_type push_data, pop_data;
   logic    q_push, q_full, q_pop, q_empty;

   dhhm_front #(
      .MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT), .TARGET_COUNT(TARGET_COUNT)
   ) u_front (
      .clock, .reset, .req_push, .req_full, .req_op, .req_target_id,
      .req_pos_x, .req_pos_y, .req_coef_index, .req_coef_value,
      .req_map_addr, .req_map_value,
      .q_push(q_push), .q_data(push_data), .q_full(q_full)
   );

   dhhm_fifo u_fifo (
      .clock, .reset, .push(q_push), .push_data(push_data), .full(q_full),
      .pop(q_pop), .pop_data(pop_data), .empty(q_empty)
   );

   dhhm_back #(
      .MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)
   ) u_back (
      .clock, .reset, .q_empty(q_empty), .q_data(pop_data), .q_pop(q_pop),
      .csr_valid, .csr_ready, .csr_height_threshold,
      .rsp_empty, .rsp_pop, .rsp_out_id, .rsp_map_x, .rsp_map_y,
      .rsp_on_high, .rsp_valid_res, .rsp_no_data
   );

endmodule

### tb/sv/dhhm_checker.sv
`timescale 1ns / 1ps
// Checker for the dual homography height map remap block: watches all three channels,
// predicts each remap result and compares it with what the block delivers.
// Depends on dhhm_pkg.
module dhhm_checker import dhhm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_target_id,
   input  logic [15:0]        req_pos_x,
   input  logic [15:0]        req_pos_y,
   input  logic [4:0]         req_coef_index,
   input  logic signed [31:0] req_coef_value,
   input  logic [16:0]        req_map_addr,
   input  logic [7:0]         req_map_value,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [3:0]         rsp_out_id,
   input  logic [8:0]         rsp_map_x,
   input  logic [7:0]         rsp_map_y,
   input  logic               rsp_on_high,
   input  logic               rsp_valid_res,
   input  logic               rsp_no_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_height_threshold,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [3:0] id;
      logic [8:0] x;
      logic [7:0] y;
      logic       high;
      logic       valid;
      logic       nodata;
      logic       known;
   } remap_result_type;

   localparam int MAP_ENTRIES = MAP_WIDTH_DEF * MAP_HEIGHT_DEF;

   remap_result_type   remap_q[$];
   logic [7:0]         threshold;
   logic [31:0]        positions[TARGET_COUNT_DEF];
   logic signed [31:0] coefs[COEF_COUNT];
   logic [7:0]         height_map[MAP_ENTRIES];
   bit                 map_set[MAP_ENTRIES];

   function automatic longint plane_row(int b, logic [15:0] x, logic [15:0] y);
      return longint'(coefs[b]) * longint'({48'd0, x}) + longint'(coefs[b + 1])
         * longint'({48'd0, y}) + longint'(coefs[b + 2]) * 64'sd16;
   endfunction

   task automatic project(input int b, input logic [15:0] x, input logic [15:0] y,
                          output bit ok, output longint px, output longint py);
      longint w;
      w = plane_row(b + 6, x, y);
      ok = (w != 0);
      px = ok ? plane_row(b, x, y) / w : 0;
      py = ok ? plane_row(b + 3, x, y) / w : 0;
   endtask

   // A high point on a map entry that was never written leaves the choice open.
   task automatic remap_point(output remap_result_type r);
      logic [15:0] ox, oy, sx, sy;
      longint      hx, hy, lx, ly, addr;
      bit          hok, lok, ok;
      logic [7:0]  h;
      ox = positions[req_target_id][15:0];
      oy = positions[req_target_id][31:16];
      if (ox == 0 && oy == 0) begin
         sx = req_pos_x;
         sy = req_pos_y;
      end else begin
         sx = 16'((17'(ox) + 17'(req_pos_x)) >> 1);
         sy = 16'((17'(oy) + 17'(req_pos_y)) >> 1);
      end
      positions[req_target_id] = {sy, sx};
      project(0, sx, sy, hok, hx, hy);
      project(9, sx, sy, lok, lx, ly);
      ok = hok && lok && hx > 0 && hy > 0 && lx > 0 && ly > 0
         && hx < MAP_WIDTH_DEF && hy < MAP_HEIGHT_DEF;
      r = '0;
      r.id = req_target_id;
      r.valid = ok;
      r.nodata = (sx == 0 && sy == 0);
      r.known = 1'b1;
      if (ok) begin
         addr = hy * MAP_WIDTH_DEF + hx;
         r.known = map_set[addr];
         h = height_map[addr];
         r.high = (h > threshold);
         r.x = r.high ? hx[8:0] : lx[8:0];
         r.y = r.high ? hy[7:0] : ly[7:0];
      end
   endtask

   task automatic report(string field, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      remap_result_type r;
      if (reset) begin
         threshold = THRESH_RESET;
         foreach (positions[i]) positions[i] = '0;
         foreach (coefs[i]) coefs[i] = '0;
         foreach (map_set[i]) map_set[i] = 1'b0;
         remap_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            threshold = csr_height_threshold;
         if (rsp_pop && !rsp_empty) begin
            if (remap_q.size() == 0) begin
               $display("unexpected result transfer at %0t, id %0d", $time, rsp_out_id);
               fail_count++;
            end else begin
               r = remap_q.pop_front();
               if (rsp_out_id != r.id) report("out_id", rsp_out_id, r.id);
               if (r.known && rsp_map_x != r.x) report("map_x", rsp_map_x, r.x);
               if (r.known && rsp_map_y != r.y) report("map_y", rsp_map_y, r.y);
               if (r.known && rsp_on_high != r.high)
                  report("on_high", rsp_on_high, r.high);
               if (rsp_valid_res != r.valid) report("valid_res", rsp_valid_res, r.valid);
               if (rsp_no_data != r.nodata) report("no_data", rsp_no_data, r.nodata);
            end
         end
         if (req_push && !req_full) begin
            case (req_op)
               OP_POINT: begin
                  remap_point(r);
                  remap_q.push_back(r);
               end
               OP_COEF: if (req_coef_index < COEF_COUNT) coefs[req_coef_index] = req_coef_value;
               OP_MAP: begin
                  height_map[req_map_addr] = req_map_value;
                  map_set[req_map_addr] = 1'b1;
               end
               default: ;
            endcase
         end
      end
      pending = remap_q.size();
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the dual homography height map remap block: drives point, coefficient
// and map transfers and threshold writes. Depends on dhhm_pkg, the block and dhhm_checker.
module tb_top;
   import dhhm_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_op = '0;
   logic [3:0]         req_target_id = '0;
   logic [15:0]        req_pos_x = '0;
   logic [15:0]        req_pos_y = '0;
   logic [4:0]         req_coef_index = '0;
   logic signed [31:0] req_coef_value = '0;
   logic [16:0]        req_map_addr = '0;
   logic [7:0]         req_map_value = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [3:0]         rsp_out_id;
   logic [8:0]         rsp_map_x;
   logic [7:0]         rsp_map_y;
   logic               rsp_on_high;
   logic               rsp_valid_res;
   logic               rsp_no_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [7:0]         csr_height_threshold = '0;
   int                 fail_count;
   int                 pending;
   bit                 gaps_on = 1'b0;
   int                 pop_hold = 0;

   dual_homography_height_map_remap u_top (.*);

   dhhm_checker u_chk (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
         pop_hold <= $urandom_range(0, 17);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   task automatic send(op_type op, logic [3:0] id, logic [15:0] x, logic [15:0] y,
                       logic [4:0] ci, logic [31:0] cv, logic [16:0] ma, logic [7:0] mv);
      if (gaps_on && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= op;
      req_target_id <= id;
      req_pos_x <= x;
      req_pos_y <= y;
      req_coef_index <= ci;
      req_coef_value <= cv;
      req_map_addr <= ma;
      req_map_value <= mv;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_point(logic [3:0] id, logic [15:0] x, logic [15:0] y);
      send(OP_POINT, id, x, y, 5'($urandom), $urandom, 17'($urandom), 8'($urandom));
   endtask

   task automatic send_coef(logic [4:0] ci, logic [31:0] cv);
      send(OP_COEF, 4'($urandom), 16'($urandom), 16'($urandom), ci, cv,
           17'($urandom), 8'($urandom));
   endtask

   task automatic load_plane(int p);
      send_coef(5'(p * 9 + 0), $urandom_range(2000, 9000));
      send_coef(5'(p * 9 + 1), 32'($urandom_range(0, 800)) - 32'd400);
      send_coef(5'(p * 9 + 2), 32'($urandom_range(0, 40)) << 16);
      send_coef(5'(p * 9 + 3), 32'($urandom_range(0, 400)) - 32'd200);
      send_coef(5'(p * 9 + 4), $urandom_range(1000, 4500));
      send_coef(5'(p * 9 + 5), 32'($urandom_range(0, 30)) << 16);
      send_coef(5'(p * 9 + 6), 32'($urandom_range(0, 40)) - 32'd20);
      send_coef(5'(p * 9 + 7), 32'($urandom_range(0, 40)) - 32'd20);
      send_coef(5'(p * 9 + 8), 32'h0001_0000 + 32'($urandom_range(0, 8192)) - 32'd4096);
   endtask

   task automatic load_planes();
      load_plane(0);
      load_plane(1);
   endtask

   // The high plane maps every position to one map cell, which is written first.
   task automatic load_fixed_planes();
      int cx, cy;
      cx = $urandom_range(1, MAP_WIDTH_DEF - 1);
      cy = $urandom_range(1, MAP_HEIGHT_DEF - 1);
      send(OP_MAP, '0, '0, '0, '0, '0, 17'(cy * MAP_WIDTH_DEF + cx), 8'($urandom));
      send_coef(5'd0, 32'd0);
      send_coef(5'd1, 32'd0);
      send_coef(5'd2, 32'(cx) << 16);
      send_coef(5'd3, 32'd0);
      send_coef(5'd4, 32'd0);
      send_coef(5'd5, 32'(cy) << 16);
      send_coef(5'd6, 32'd0);
      send_coef(5'd7, 32'd0);
      send_coef(5'd8, 32'h0001_0000);
      load_plane(1);
   endtask

   task automatic write_threshold(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_height_threshold <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_pos();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [7:0] phase_thresh[5];
      phase_thresh = '{8'd255, 8'd150, 8'($urandom), 8'd0, 8'($urandom)};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_threshold(8'd0);

      // Directed: zero coefficients, zero position, averaging, extremes, ignored items.
      send_point(4'd0, 16'd0, 16'd0);
      send_point(4'd15, 16'hFFFF, 16'hFFFF);
      load_planes();
      send_point(4'd0, 16'h1234, 16'h0567);
      send_point(4'd0, 16'hFFFF, 16'hFFFF);
      send_point(4'd15, 16'd0, 16'd0);
      send(OP_SPARE, 4'd1, 16'h4000, 16'h1000, 5'd0, 32'd0, 17'd0, 8'd0);
      send_coef(5'd31, 32'h7FFF_FFFF);
      send_coef(5'd18, 32'h8000_0000);
      send_point(4'd1, 16'h2000, 16'h0800);
      send(OP_MAP, '0, '0, '0, '0, '0, 17'h1FFFF, 8'hFF);
      send(OP_MAP, '0, '0, '0, '0, '0, 17'h00000, 8'h00);
      send_coef(5'd17, 32'd0);
      send_coef(5'd15, 32'd0);
      send_coef(5'd16, 32'd0);
      send_point(4'd2, 16'h3000, 16'h0900);
      send_coef(5'd0, 32'h8000_0000);
      send_coef(5'd9, 32'h7FFF_FFFF);
      send_point(4'd3, 16'hFFFF, 16'h0001);
      load_fixed_planes();
      send_point(4'd4, 16'h2000, 16'h1000);
      send_point(4'd5, 16'h0800, 16'h0400);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_threshold(phase_thresh[p]);
         gaps_on = (p < 4);
         if (p % 2 == 0)
            load_planes();
         else
            load_fixed_planes();
         for (int n = 0; n < 160; n++) begin
            case ($urandom_range(0, 39))
               0: if ($urandom_range(0, 1) == 0) load_planes(); else load_fixed_planes();
               1, 2: send_coef(5'($urandom_range(0, 17)), $urandom);
               3, 4, 5: send_coef(5'($urandom_range(0, 17)),
                                  32'($urandom_range(0, 20000)) - 32'd10000);
               6: send_coef(5'($urandom_range(18, 31)), $urandom);
               7, 8, 9, 10: send(OP_MAP, '0, '0, '0, '0, '0, 17'($urandom), 8'($urandom));
               11: send(OP_SPARE, 4'($urandom), 16'($urandom), 16'($urandom),
                        5'($urandom), $urandom, 17'($urandom), 8'($urandom));
               default: send_point(4'($urandom), rand_pos(), rand_pos());
            endcase
         end
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("dual_homography_height_map_remap regression: pass");
      else
         $display("dual_homography_height_map_remap regression: fail");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("dual_homography_height_map_remap regression: fail");
      $finish;
   end

endmodule

### files.f
rtl/dhhm_pkg.sv
rtl/dhhm_fifo.sv
rtl/dhhm_front.sv
rtl/dhhm_div.sv
rtl/dhhm_back.sv
rtl/dual_homography_height_map_remap.sv
tb/sv/dhhm_checker.sv
tb/sv/tb_top.sv
